// ===== hdl/uvwn_pkg.sv =====
// Shared types, constants and the whitespace classifier of the UTF-8 normalizer.
package uvwn_pkg;

   localparam int DEF_PEND_DEPTH = 32;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [7:0]  LEAD2_LO    = 8'hc2;
   localparam logic [7:0]  LEAD2_HI    = 8'hdf;
   localparam logic [7:0]  LEAD3_LO    = 8'he0;
   localparam logic [7:0]  LEAD3_HI    = 8'hef;
   localparam logic [7:0]  LEAD4_LO    = 8'hf0;
   localparam logic [7:0]  LEAD4_HI    = 8'hf4;
   localparam logic [1:0]  CONT_TAG    = 2'b10;
   localparam logic [7:0]  SPACE_BYTE  = 8'h20;

   localparam logic [20:0] MIN_LEN2    = 21'h000080;
   localparam logic [20:0] MIN_LEN3    = 21'h000800;
   localparam logic [20:0] MIN_LEN4    = 21'h010000;
   localparam logic [20:0] CP_MAX      = 21'h10ffff;
   localparam logic [20:0] SURR_LO     = 21'h00d800;
   localparam logic [20:0] SURR_HI     = 21'h00dfff;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WS_SPACE,
      OP_WS_KEEP,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [3:0][7:0] bytes;
      logic [1:0]      len_m1;
      logic            end_mark;
      logic            bad;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WS_WR,
      BK_FLUSH,
      BK_CPB,
      BK_MARK
   } back_state_type;

   function automatic logic is_space(input logic [20:0] cp);
      return (cp >= 21'h000009 && cp <= 21'h00000d) ||
             (cp >= 21'h00001c && cp <= 21'h000020) ||
             cp == 21'h000085 || cp == 21'h0000a0 || cp == 21'h001680 ||
             (cp >= 21'h002000 && cp <= 21'h00200a) ||
             cp == 21'h002028 || cp == 21'h002029 || cp == 21'h00202f ||
             cp == 21'h00205f || cp == 21'h003000;
   endfunction

endpackage

// ===== hdl/uvwn_req_if.sv =====
// Byte request channel: valid/ready handshake carrying one input byte per beat.
interface uvwn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/uvwn_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result beat.
interface uvwn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       out_last;
   logic       bad_input;

   modport source (output valid, output out_byte, output byte_present, output out_last,
                   output bad_input, input ready);
   modport sink   (input valid, input out_byte, input byte_present, input out_last,
                   input bad_input, output ready);
endinterface

// ===== hdl/utf8_validate_whitespace_normalize.sv =====
// Top level of the UTF-8 validator with whitespace strip and collapse.
//
// Usage:
//   req_bus carries one string byte per beat (in_byte) with in_last on its final byte.
//   rsp_bus returns normalized bytes (byte_present = 1) and, after the last byte of
//   each string, one end marker (byte_present = 0, out_last = 1). bad_input on the
//   marker flags invalid UTF-8 or a whitespace run longer than PEND_DEPTH bytes in
//   keep mode; the consumer then drops everything it got for that string.
//   csr_wr_en/csr_wr_data write collapse_mode (1 = interior runs become one space).
//   Write it only between strings, with no beats still in flight.
// Timing:
//   The decoder takes one byte per cycle while the 4-entry command queue has room.
//   An ASCII byte with no held whitespace passes through the command queue and then
//   the response register before rsp_bus.valid rises.
//   The back end moves one response beat per cycle while rsp_bus is ready; a flush
//   sends the n held bytes and then the k-byte code point, a kept whitespace code point
//   of k bytes is buffered byte by byte, so long runs throttle the input through the queue.
// Reset clears all per-string state and sets collapse_mode to 1. A stalled rsp_bus
// holds its beat; the back end and then the queue fill before req_bus.ready drops.
module utf8_validate_whitespace_normalize #(
   parameter int PEND_DEPTH = uvwn_pkg::DEF_PEND_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   uvwn_req_if.sink   req_bus,
   uvwn_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                 collapse_ff;
   logic                 accept;
   logic                 push;
   logic                 pop;
   uvwn_pkg::cmd_type    push_cmd;
   uvwn_pkg::cmd_type    head_cmd;
   uvwn_pkg::q_stat_type q_stat;

   // Hold the mode register; it survives string ends and changes only on a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         collapse_ff <= 1'b1;
      end else if (csr_wr_en) begin
         collapse_ff <= csr_wr_data;
      end
   end

   // Take a beat whenever the queue can absorb the command it may produce.
   assign req_bus.ready = !q_stat.full;
   assign accept        = req_bus.valid && !q_stat.full;

   uvwn_front #(
      .PEND_DEPTH (PEND_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_bus.in_byte),
      .in_last       (req_bus.in_last),
      .collapse_mode (collapse_ff),
      .push          (push),
      .cmd           (push_cmd)
   );

   uvwn_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   uvwn_back #(
      .PEND_DEPTH (PEND_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== hdl/uvwn_front.sv =====
// Front end: UTF-8 decode, validity checks, whitespace classification, command build.
module uvwn_front #(
   parameter int PEND_DEPTH = uvwn_pkg::DEF_PEND_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              collapse_mode,
   output logic              push,
   output uvwn_pkg::cmd_type cmd
);

   localparam int CW = $clog2(PEND_DEPTH + 1);

   logic [20:0]     pcp_ff, pcp_in;
   logic [1:0]      exp_ff, exp_in;
   logic [1:0]      seq_ff, seq_in;
   logic [2:0][7:0] cpb_ff, cpb_in;
   logic [CW-1:0]   run_ff, run_in;
   logic            emitted_ff, emitted_in;
   logic            err_ff, err_in;

   logic            done;
   logic            err_n;
   logic            cp_bad;
   logic [20:0]     cp;
   logic [20:0]     pcp_next;
   logic [1:0]      len_m1;
   logic [2:0]      len;
   logic [1:0]      idx;
   logic [CW:0]     run_sum;
   logic [3:0][7:0] bytes;
   uvwn_pkg::op_type op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcp_ff     <= '0;
         exp_ff     <= '0;
         seq_ff     <= '0;
         run_ff     <= '0;
         emitted_ff <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         pcp_ff     <= pcp_in;
         exp_ff     <= exp_in;
         seq_ff     <= seq_in;
         run_ff     <= run_in;
         emitted_ff <= emitted_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cpb_ff <= cpb_in;
   end

   always_comb begin
      pcp_in     = pcp_ff;
      exp_in     = exp_ff;
      seq_in     = seq_ff;
      cpb_in     = cpb_ff;
      run_in     = run_ff;
      emitted_in = emitted_ff;
      err_in     = err_ff;
      done       = 1'b0;
      err_n      = err_ff;
      cp_bad     = 1'b0;
      cp         = '0;
      len_m1     = '0;
      idx        = '0;
      pcp_next   = {pcp_ff[14:0], in_byte[5:0]};
      op         = uvwn_pkg::OP_NONE;

      if (accept && !err_ff) begin
         if (exp_ff == 2'd0) begin
            if (in_byte < uvwn_pkg::ASCII_LIMIT) begin
               done = 1'b1;
               cp   = {13'd0, in_byte};
            end else if (in_byte inside {[uvwn_pkg::LEAD2_LO:uvwn_pkg::LEAD2_HI]}) begin
               pcp_in    = {16'd0, in_byte[4:0]};
               seq_in    = 2'd1;
               exp_in    = 2'd1;
               cpb_in[0] = in_byte;
            end else if (in_byte inside {[uvwn_pkg::LEAD3_LO:uvwn_pkg::LEAD3_HI]}) begin
               pcp_in    = {17'd0, in_byte[3:0]};
               seq_in    = 2'd2;
               exp_in    = 2'd2;
               cpb_in[0] = in_byte;
            end else if (in_byte inside {[uvwn_pkg::LEAD4_LO:uvwn_pkg::LEAD4_HI]}) begin
               pcp_in    = {18'd0, in_byte[2:0]};
               seq_in    = 2'd3;
               exp_in    = 2'd3;
               cpb_in[0] = in_byte;
            end else begin
               err_n = 1'b1;
            end
         end else if (in_byte[7:6] != uvwn_pkg::CONT_TAG) begin
            err_n = 1'b1;
         end else begin
            // Position of this continuation in the sequence; only the first two are kept.
            idx = seq_ff - exp_ff + 2'd1;
            if (idx == 2'd1) begin
               cpb_in[1] = in_byte;
            end
            if (idx == 2'd2) begin
               cpb_in[2] = in_byte;
            end
            pcp_in = pcp_next;
            exp_in = exp_ff - 2'd1;
            if (exp_ff == 2'd1) begin
               done   = 1'b1;
               cp     = pcp_next;
               len_m1 = seq_ff;
            end
         end
      end

      len = {1'b0, len_m1} + 3'd1;

      bytes[0] = (len_m1 == 2'd0) ? in_byte : cpb_ff[0];
      bytes[1] = (len_m1 == 2'd1) ? in_byte : cpb_ff[1];
      bytes[2] = (len_m1 == 2'd2) ? in_byte : cpb_ff[2];
      bytes[3] = in_byte;

      run_sum = {1'b0, run_ff} + (CW+1)'(len);

      if (done) begin
         case (len_m1)
            2'd1:    cp_bad = cp < uvwn_pkg::MIN_LEN2;
            2'd2:    cp_bad = cp < uvwn_pkg::MIN_LEN3;
            2'd3:    cp_bad = cp < uvwn_pkg::MIN_LEN4;
            default: cp_bad = 1'b0;
         endcase
         if (cp > uvwn_pkg::CP_MAX || (cp >= uvwn_pkg::SURR_LO && cp <= uvwn_pkg::SURR_HI)) begin
            cp_bad = 1'b1;
         end

         if (cp_bad) begin
            err_n = 1'b1;
         end else if (uvwn_pkg::is_space(cp)) begin
            // Leading whitespace is dropped outright.
            if (emitted_ff) begin
               if (collapse_mode) begin
                  op     = uvwn_pkg::OP_WS_SPACE;
                  run_in = CW'(1);
               end else if (run_sum > (CW+1)'(PEND_DEPTH)) begin
                  err_n = 1'b1;
               end else begin
                  op     = uvwn_pkg::OP_WS_KEEP;
                  run_in = run_sum[CW-1:0];
               end
            end
         end else begin
            op         = uvwn_pkg::OP_EMIT;
            run_in     = '0;
            emitted_in = 1'b1;
         end
      end

      err_in = err_n;

      if (accept && in_last) begin
         if (exp_in != 2'd0) begin
            err_n = 1'b1;
         end
         // Trailing whitespace never reaches the output.
         if (op == uvwn_pkg::OP_WS_SPACE || op == uvwn_pkg::OP_WS_KEEP) begin
            op = uvwn_pkg::OP_NONE;
         end
         pcp_in     = '0;
         exp_in     = '0;
         seq_in     = '0;
         run_in     = '0;
         emitted_in = 1'b0;
         err_in     = 1'b0;
      end

      push         = accept && (op != uvwn_pkg::OP_NONE || in_last);
      cmd.op       = op;
      cmd.bytes    = bytes;
      cmd.len_m1   = len_m1;
      cmd.end_mark = in_last;
      cmd.bad      = err_n;
   end

endmodule

// ===== hdl/uvwn_cmd_queue.sv =====
// Short command queue that decouples the decode front end from the output back end.
module uvwn_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  uvwn_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output uvwn_pkg::cmd_type    head_cmd,
   output uvwn_pkg::q_stat_type stat
);

   localparam int QAW = $clog2(uvwn_pkg::QUEUE_DEPTH);

   uvwn_pkg::cmd_type entry_ff [uvwn_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]    wptr_ff, wptr_in;
   logic [QAW-1:0]    rptr_ff, rptr_in;
   logic [QAW:0]      count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      stat.full  = count_ff == (QAW+1)'(uvwn_pkg::QUEUE_DEPTH);
      stat.empty = count_ff == '0;
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      wptr_in    = do_push ? ((wptr_ff == QAW'(uvwn_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1)
                           : wptr_ff;
      rptr_in    = do_pop ? ((rptr_ff == QAW'(uvwn_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1)
                          : rptr_ff;
      count_in   = count_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
      head_cmd   = entry_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("command pushed into a full queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !do_push && !do_pop |=> $stable(count_ff))
      else $error("queue fill changed without a push or pop");

endmodule

// ===== hdl/uvwn_back.sv =====
// Back end: whitespace run buffer, flush sequencing and the registered response stage.
module uvwn_back #(
   parameter int PEND_DEPTH = uvwn_pkg::DEF_PEND_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uvwn_pkg::cmd_type    head_cmd,
   input  uvwn_pkg::q_stat_type q_stat,
   output logic                 pop,
   uvwn_rsp_if.source           rsp_bus
);

   localparam int CW = $clog2(PEND_DEPTH + 1);
   localparam int AW = $clog2(PEND_DEPTH);

   uvwn_pkg::back_state_type state_ff, state_in;
   uvwn_pkg::cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [1:0]               k_ff, k_in;

   logic [7:0]               run_mem [PEND_DEPTH];
   logic [7:0]               rd_data_ff;
   logic                     we;
   logic [AW-1:0]            waddr;
   logic [7:0]               wdata;

   logic                     vld_ff, vld_in;
   logic [7:0]               byte_ff;
   logic                     present_ff;
   logic                     last_ff;
   logic                     bad_ff;

   logic                     out_free;
   logic                     emit;
   logic [7:0]               e_byte;
   logic                     e_present;
   logic                     e_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvwn_pkg::BK_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      k_ff   <= k_in;
      if (emit) begin
         byte_ff    <= e_byte;
         present_ff <= e_present;
         last_ff    <= !e_present;
         bad_ff     <= e_bad;
      end
   end

   // Run buffer: one write port, one registered read that tracks the flush index.
   always_ff @(posedge clock) begin
      if (we) begin
         run_mem[waddr] <= wdata;
      end
      rd_data_ff <= run_mem[idx_in];
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      pop       = 1'b0;
      we        = 1'b0;
      waddr     = cnt_ff[AW-1:0];
      wdata     = cmd_ff.bytes[k_ff];
      out_free  = !vld_ff || rsp_bus.ready;
      emit      = 1'b0;
      e_byte    = '0;
      e_present = 1'b1;
      e_bad     = 1'b0;

      case (state_ff)
         uvwn_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               k_in   = '0;
               idx_in = '0;
               case (head_cmd.op)
                  uvwn_pkg::OP_WS_SPACE: begin
                     we     = 1'b1;
                     waddr  = '0;
                     wdata  = uvwn_pkg::SPACE_BYTE;
                     cnt_in = CW'(1);
                     if (head_cmd.end_mark) begin
                        state_in = uvwn_pkg::BK_MARK;
                     end
                  end
                  uvwn_pkg::OP_WS_KEEP: begin
                     state_in = uvwn_pkg::BK_WS_WR;
                  end
                  uvwn_pkg::OP_EMIT: begin
                     if (cnt_ff != '0) begin
                        state_in = uvwn_pkg::BK_FLUSH;
                     end else if (out_free) begin
                        // Nothing held: send the first byte straight away.
                        emit   = 1'b1;
                        e_byte = head_cmd.bytes[0];
                        k_in   = 2'd1;
                        if (head_cmd.len_m1 != 2'd0) begin
                           state_in = uvwn_pkg::BK_CPB;
                        end else if (head_cmd.end_mark) begin
                           state_in = uvwn_pkg::BK_MARK;
                        end
                     end else begin
                        state_in = uvwn_pkg::BK_CPB;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        emit      = 1'b1;
                        e_present = 1'b0;
                        e_bad     = head_cmd.bad;
                        cnt_in    = '0;
                     end else begin
                        state_in = uvwn_pkg::BK_MARK;
                     end
                  end
               endcase
            end
         end

         uvwn_pkg::BK_WS_WR: begin
            we     = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            k_in   = k_ff + 2'd1;
            if (k_ff == cmd_ff.len_m1) begin
               state_in = uvwn_pkg::BK_IDLE;
            end
         end

         uvwn_pkg::BK_FLUSH: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = rd_data_ff;
               idx_in = idx_ff + 1'b1;
               if (CW'(idx_ff) == cnt_ff - 1'b1) begin
                  state_in = uvwn_pkg::BK_CPB;
                  cnt_in   = '0;
               end
            end
         end

         uvwn_pkg::BK_CPB: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = cmd_ff.bytes[k_ff];
               k_in   = k_ff + 2'd1;
               if (k_ff == cmd_ff.len_m1) begin
                  state_in = cmd_ff.end_mark ? uvwn_pkg::BK_MARK : uvwn_pkg::BK_IDLE;
               end
            end
         end

         uvwn_pkg::BK_MARK: begin
            if (out_free) begin
               emit      = 1'b1;
               e_present = 1'b0;
               e_bad     = cmd_ff.bad;
               cnt_in    = '0;
               state_in  = uvwn_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = uvwn_pkg::BK_IDLE;
         end
      endcase

      vld_in = emit ? 1'b1 : (rsp_bus.ready ? 1'b0 : vld_ff);
   end

   assign rsp_bus.valid        = vld_ff;
   assign rsp_bus.out_byte     = byte_ff;
   assign rsp_bus.byte_present = present_ff;
   assign rsp_bus.out_last     = last_ff;
   assign rsp_bus.bad_input    = bad_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(PEND_DEPTH))
      else $error("whitespace run exceeds buffer depth");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == uvwn_pkg::BK_FLUSH |-> cnt_ff != '0)
      else $error("flush with an empty run buffer");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !present_ff |-> last_ff && byte_ff == '0)
      else $error("end marker malformed");

   a_no_emit_over_stall: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_bus.ready |-> !emit)
      else $error("response register overwritten while stalled");

endmodule
